// ===== design/ttss_pkg.sv =====
// Shared widths, reset values, register indexes, sequencer types and status bundle.
`timescale 1ns / 1ps
package ttss_pkg;

    localparam int TABLE_ENTRIES_DEF = 9;
    localparam int TAP_LIMIT_DEF     = 4;

    localparam int PCT_W     = 7;
    localparam int ERPM_W    = 17;
    localparam int TABLE_W   = 63;
    localparam int WIN_W     = 16;
    localparam int DEB_W     = 8;
    localparam int START_W   = 4;
    localparam int TOTAL_W   = 3;
    localparam int TARGET_W  = 18;
    localparam int LEVEL_W   = 4;
    localparam int CFG_IDX_W = 3;

    localparam int PROD_W    = PCT_W + ERPM_W;
    localparam int RECIP_W   = 25;
    localparam int MUL_W     = PROD_W + RECIP_W;
    localparam int DIV_SHIFT = 31;
    localparam logic [RECIP_W-1:0] DIV_RECIP = RECIP_W'(((64'd1 << DIV_SHIFT) + 64'd99) / 64'd100);

    localparam logic [TABLE_W-1:0] SPEED_TABLE_RST = 63'd7253941903918778250;
    localparam logic [ERPM_W-1:0]  MAX_ERPM_RST    = 17'd8000;
    localparam logic [PCT_W-1:0]   REVERSE_PCT_RST = 7'd20;
    localparam logic [WIN_W-1:0]   TAP_WINDOW_RST  = 16'd125;
    localparam logic [DEB_W-1:0]   DEBOUNCE_RST    = 8'd10;
    localparam logic [START_W-1:0] START_INDEX_RST = 4'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SPEED_TABLE = 3'd0,
        REG_MAX_ERPM    = 3'd1,
        REG_REVERSE_PCT = 3'd2,
        REG_TAP_WINDOW  = 3'd3,
        REG_DEBOUNCE    = 3'd4,
        REG_START_INDEX = 3'd5
    } cfg_reg_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_TICK,
        OP_PRESS_SCAN,
        OP_EVENTS,
        OP_DOWN_SCAN,
        OP_UP_SCAN,
        OP_MUL1,
        OP_MUL2,
        OP_RESULT
    } op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TICK,
        S_PRESS,
        S_EVENTS,
        S_DOWN,
        S_UP,
        S_MUL1,
        S_MUL2,
        S_RESULT
    } state_t;

    typedef struct packed {
        logic holdoff_busy;
        logic press_go;
        logic go_down;
        logic go_up;
        logic scan_done;
        logic out_free;
    } dp_status_t;

endpackage

// ===== design/trigger_tap_speed_selector.sv =====
// Top level: trigger tap speed selector, sequencer plus datapath.
`timescale 1ns / 1ps
// Each transfer on the input is one trigger sample of a periodic tick and yields exactly one
// result transfer: a signed speed target, a coast flag, the current table level and the
// reverse flag. A tick first loads the sample and counts down the window and hold-off timers;
// unless the sample falls in the debounce hold-off, it then runs the tap event step, preceded
// by a table scan when a press starts from stop and followed by one when a tap command steps
// up or down. Every tick includes two multiplier stages for the percent scaling. A finished
// result waits in the output register, so the next sample can be taken before the previous
// result is collected; a result that finds the register still full holds the sequencer until
// it drains. Configuration registers are written by index through the write port; the user
// must write them only while no tick is in progress, as the block itself does not enforce it.
module trigger_tap_speed_selector #(
    parameter int TABLE_ENTRIES = ttss_pkg::TABLE_ENTRIES_DEF,
    parameter int TAP_LIMIT     = ttss_pkg::TAP_LIMIT_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [ttss_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ttss_pkg::TABLE_W-1:0]         cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 trigger,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [ttss_pkg::TARGET_W-1:0] speed_target,
    output logic                                 motor_release,
    output logic [ttss_pkg::LEVEL_W-1:0]         speed_level,
    output logic                                 reverse_active
);
    import ttss_pkg::*;

    op_t        op;
    dp_status_t status;

    ttss_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .op       (op)
    );

    ttss_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .TAP_LIMIT     (TAP_LIMIT)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .trigger        (trigger),
        .op             (op),
        .status         (status),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .speed_target   (speed_target),
        .motor_release  (motor_release),
        .speed_level    (speed_level),
        .reverse_active (reverse_active)
    );

endmodule

// ===== design/ttss_datapath.sv =====
// Datapath: configuration, tap state, table scan, target scaling and output register.
`timescale 1ns / 1ps
module ttss_datapath #(
    parameter int TABLE_ENTRIES = ttss_pkg::TABLE_ENTRIES_DEF,
    parameter int TAP_LIMIT     = ttss_pkg::TAP_LIMIT_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [ttss_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ttss_pkg::TABLE_W-1:0]         cfg_data,
    input  logic                                 trigger,
    input  ttss_pkg::op_t                        op,
    output ttss_pkg::dp_status_t                 status,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [ttss_pkg::TARGET_W-1:0] speed_target,
    output logic                                 motor_release,
    output logic [ttss_pkg::LEVEL_W-1:0]         speed_level,
    output logic                                 reverse_active
);
    import ttss_pkg::*;

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CNT_W-1:0]   TE_C   = CNT_W'(TABLE_ENTRIES);
    localparam logic [CNT_W-1:0]   LAST_C = CNT_W'(TABLE_ENTRIES - 1);
    localparam logic [START_W-1:0] LAST_S = START_W'(TABLE_ENTRIES - 1);
    localparam logic [TOTAL_W-1:0] LIMIT_C = TOTAL_W'(TAP_LIMIT);

    logic [TABLE_W-1:0] table_reg;
    logic [ERPM_W-1:0]  max_erpm_reg;
    logic [PCT_W-1:0]   rev_pct_reg;
    logic [WIN_W-1:0]   tap_window_reg;
    logic [DEB_W-1:0]   debounce_reg;
    logic [START_W-1:0] start_reg;

    logic [IDX_W-1:0]   idx_reg;
    logic [PCT_W-1:0]   ap_reg;
    logic               open_reg;
    logic               counted_reg;
    logic [TOTAL_W-1:0] total_reg;
    logic [WIN_W-1:0]   timer_reg;
    logic               wrun_reg;
    logic               wexp_reg;
    logic               rev_reg;
    logic [DEB_W-1:0]   holdoff_reg;
    logic               out_valid_reg;

    logic                       trig_reg;
    logic [CNT_W-1:0]           scan_reg;
    logic [PROD_W-1:0]          prod_reg;
    logic [TARGET_W-1:0]        quot_reg;
    logic signed [TARGET_W-1:0] target_out_reg;
    logic                       release_out_reg;
    logic [LEVEL_W-1:0]         level_out_reg;
    logic                       rev_out_reg;

    logic [PCT_W-1:0]   ent [TABLE_ENTRIES];
    logic [PCT_W-1:0]   scan_ent;
    logic [IDX_W-1:0]   start_pos;
    logic [IDX_W-1:0]   commit_idx;
    logic [PCT_W-1:0]   commit_ap;
    logic [WIN_W-1:0]   timer_dec;
    logic [WIN_W-1:0]   win_load;
    logic               ev_b;
    logic               ev_c;
    logic               ev_d;
    logic [TOTAL_W-1:0] tot_inc;
    logic               at_limit;
    logic               win_start;
    logic               exp_fin;
    logic [TOTAL_W-1:0] tot_fin;
    logic               act_stop;
    logic               act_down;
    logic               act_rev;
    logic               act_up;
    logic [PCT_W-1:0]   pct_sel;
    logic [MUL_W-1:0]   recip_prod;
    logic [ERPM_W-1:0]  mag;
    logic [TARGET_W-1:0] mag_ext;

    always_comb
    begin
        for (int k = 0; k < TABLE_ENTRIES; k++)
        begin
            ent[k] = table_reg[k*PCT_W +: PCT_W];
        end
    end

    assign scan_ent = (scan_reg < TE_C) ? ent[scan_reg[IDX_W-1:0]] : '0;

    always_comb
    begin
        if (start_reg == '0)
            start_pos = IDX_W'(1);
        else if (start_reg > LAST_S)
            start_pos = IDX_W'(TABLE_ENTRIES - 1);
        else
            start_pos = start_reg[IDX_W-1:0];
    end

    always_comb
    begin
        commit_idx = scan_reg[IDX_W-1:0];
        commit_ap  = scan_ent;
        case (op)
            OP_UP_SCAN:
            begin
                if (scan_reg >= TE_C)
                begin
                    commit_idx = IDX_W'(TABLE_ENTRIES - 1);
                    commit_ap  = ent[TABLE_ENTRIES-1];
                end
            end
            OP_DOWN_SCAN:
            begin
                if (scan_reg == '0)
                begin
                    commit_idx = IDX_W'(1);
                    commit_ap  = ent[1];
                end
            end
            default:
            begin
                commit_idx = scan_reg[IDX_W-1:0];
            end
        endcase
    end

    assign timer_dec = (timer_reg != '0) ? timer_reg - WIN_W'(1) : '0;
    assign win_load  = (tap_window_reg != '0) ? tap_window_reg : WIN_W'(1);

    assign ev_b      = !trig_reg && !open_reg && (idx_reg != '0);
    assign ev_c      = trig_reg && open_reg && !counted_reg;
    assign ev_d      = !trig_reg && open_reg && counted_reg;
    assign tot_inc   = total_reg + TOTAL_W'(1);
    assign at_limit  = tot_inc >= LIMIT_C;
    assign win_start = ev_b || (ev_c && !at_limit) || ev_d;
    assign exp_fin   = (ev_c && at_limit) || (!win_start && wexp_reg);
    assign tot_fin   = ev_b ? '0 : (ev_c ? tot_inc : total_reg);
    assign act_stop  = !trig_reg && (tot_fin == '0);
    assign act_down  = !act_stop && trig_reg && (tot_fin == TOTAL_W'(1));
    assign act_rev   = !act_stop && !act_down && (tot_fin == LIMIT_C);
    assign act_up    = !act_stop && !act_down && !act_rev && trig_reg
                       && (tot_fin == TOTAL_W'(2));

    always_comb
    begin
        status.holdoff_busy = holdoff_reg != '0;
        status.press_go     = (holdoff_reg == '0) && (idx_reg == '0) && trig_reg;
        status.go_down      = exp_fin && act_down && (idx_reg != '0);
        status.go_up        = exp_fin && act_up && (idx_reg != '0);
        status.out_free     = !out_valid_reg || out_ready;
        case (op)
            OP_PRESS_SCAN: status.scan_done = (scan_ent != '0) || (scan_reg >= LAST_C);
            OP_UP_SCAN:    status.scan_done = (scan_reg >= TE_C) || (scan_ent != '0);
            OP_DOWN_SCAN:  status.scan_done = (scan_reg == '0) || (scan_ent != '0);
            default:       status.scan_done = 1'b0;
        endcase
    end

    assign pct_sel    = rev_reg ? rev_pct_reg : ap_reg;
    assign recip_prod = MUL_W'(prod_reg) * MUL_W'(DIV_RECIP);
    assign mag        = (quot_reg > TARGET_W'(max_erpm_reg)) ? max_erpm_reg
                                                               : quot_reg[ERPM_W-1:0];
    assign mag_ext    = TARGET_W'(mag);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_reg      <= SPEED_TABLE_RST;
            max_erpm_reg   <= MAX_ERPM_RST;
            rev_pct_reg    <= REVERSE_PCT_RST;
            tap_window_reg <= TAP_WINDOW_RST;
            debounce_reg   <= DEBOUNCE_RST;
            start_reg      <= START_INDEX_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_SPEED_TABLE: table_reg      <= cfg_data;
                REG_MAX_ERPM:    max_erpm_reg   <= cfg_data[ERPM_W-1:0];
                REG_REVERSE_PCT: rev_pct_reg    <= cfg_data[PCT_W-1:0];
                REG_TAP_WINDOW:  tap_window_reg <= cfg_data[WIN_W-1:0];
                REG_DEBOUNCE:    debounce_reg   <= cfg_data[DEB_W-1:0];
                REG_START_INDEX: start_reg      <= cfg_data[START_W-1:0];
                default:         table_reg      <= table_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            ap_reg        <= '0;
            open_reg      <= 1'b0;
            counted_reg   <= 1'b0;
            total_reg     <= '0;
            timer_reg     <= '0;
            wrun_reg      <= 1'b0;
            wexp_reg      <= 1'b0;
            rev_reg       <= 1'b0;
            holdoff_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (op == OP_RESULT)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            case (op)
                OP_TICK:
                begin
                    if (wrun_reg)
                    begin
                        timer_reg <= timer_dec;
                        if (timer_dec == '0)
                        begin
                            wrun_reg <= 1'b0;
                            wexp_reg <= 1'b1;
                        end
                    end
                    if (holdoff_reg != '0)
                        holdoff_reg <= holdoff_reg - DEB_W'(1);
                end
                OP_PRESS_SCAN, OP_UP_SCAN, OP_DOWN_SCAN:
                begin
                    if (status.scan_done)
                    begin
                        idx_reg <= commit_idx;
                        ap_reg  <= commit_ap;
                    end
                end
                OP_EVENTS:
                begin
                    if (ev_b)
                    begin
                        open_reg    <= 1'b1;
                        total_reg   <= '0;
                        counted_reg <= 1'b0;
                    end
                    if (ev_c)
                    begin
                        total_reg <= tot_inc;
                        if (!at_limit)
                            counted_reg <= 1'b1;
                    end
                    if (ev_d)
                        counted_reg <= 1'b0;
                    if (win_start)
                    begin
                        timer_reg   <= win_load;
                        wrun_reg    <= 1'b1;
                        wexp_reg    <= 1'b0;
                        holdoff_reg <= debounce_reg;
                    end
                    if (exp_fin)
                    begin
                        wexp_reg    <= 1'b0;
                        wrun_reg    <= 1'b0;
                        timer_reg   <= '0;
                        counted_reg <= 1'b0;
                        open_reg    <= 1'b0;
                        if (act_stop)
                        begin
                            idx_reg <= '0;
                            ap_reg  <= '0;
                            rev_reg <= 1'b0;
                        end
                        else if (act_rev)
                            rev_reg <= 1'b1;
                        else if ((act_down || act_up) && (idx_reg == '0))
                            idx_reg <= start_pos;
                    end
                end
                default:
                begin
                    holdoff_reg <= holdoff_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (op)
            OP_LOAD:
            begin
                trig_reg <= trigger;
            end
            OP_TICK:
            begin
                scan_reg <= CNT_W'(start_pos);
            end
            OP_EVENTS:
            begin
                if (act_down)
                    scan_reg <= (idx_reg > IDX_W'(1)) ? CNT_W'(idx_reg) - CNT_W'(1)
                                                      : CNT_W'(1);
                else
                    scan_reg <= CNT_W'(idx_reg) + CNT_W'(1);
            end
            OP_PRESS_SCAN, OP_UP_SCAN:
            begin
                if (!status.scan_done)
                    scan_reg <= scan_reg + CNT_W'(1);
            end
            OP_DOWN_SCAN:
            begin
                if (!status.scan_done)
                    scan_reg <= scan_reg - CNT_W'(1);
            end
            OP_MUL1:
            begin
                prod_reg <= PROD_W'(pct_sel) * PROD_W'(max_erpm_reg);
            end
            OP_MUL2:
            begin
                quot_reg <= recip_prod[DIV_SHIFT +: TARGET_W];
            end
            OP_RESULT:
            begin
                target_out_reg  <= rev_reg ? TARGET_W'(0) - mag_ext : mag_ext;
                release_out_reg <= !rev_reg && (ap_reg == '0);
                level_out_reg   <= LEVEL_W'(idx_reg);
                rev_out_reg     <= rev_reg;
            end
            default:
            begin
                trig_reg <= trig_reg;
            end
        endcase
    end

    assign out_valid      = out_valid_reg;
    assign speed_target   = target_out_reg;
    assign motor_release  = release_out_reg;
    assign speed_level    = level_out_reg;
    assign reverse_active = rev_out_reg;

    a_window_timer_live: assert property (@(posedge clk) disable iff (!rst_n)
        wrun_reg |-> (timer_reg != '0))
        else $error("window running with zero timer");

    a_tap_needs_command: assert property (@(posedge clk) disable iff (!rst_n)
        !open_reg |-> !counted_reg)
        else $error("tap counted outside an open command");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (op == OP_UP_SCAN || op == OP_DOWN_SCAN || op == OP_PRESS_SCAN)
        |-> (scan_reg <= TE_C))
        else $error("table scan beyond last entry");

    a_release_zero_target: assert property (@(posedge clk) disable iff (!rst_n)
        (op == OP_RESULT && !rev_reg && ap_reg == '0)
        |=> (motor_release && speed_target == '0))
        else $error("coast result with nonzero target");

endmodule

// ===== design/ttss_controller.sv =====
// Sequencer: steps one tick through countdown, scans, tap events and scaling.
`timescale 1ns / 1ps
module ttss_controller (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  ttss_pkg::dp_status_t status,
    output ttss_pkg::op_t        op
);
    import ttss_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        op         = OP_NONE;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op         = OP_LOAD;
                    state_next = S_TICK;
                end
            end
            S_TICK:
            begin
                op = OP_TICK;
                if (status.holdoff_busy)
                    state_next = S_MUL1;
                else if (status.press_go)
                    state_next = S_PRESS;
                else
                    state_next = S_EVENTS;
            end
            S_PRESS:
            begin
                op = OP_PRESS_SCAN;
                if (status.scan_done)
                    state_next = S_EVENTS;
            end
            S_EVENTS:
            begin
                op = OP_EVENTS;
                if (status.go_down)
                    state_next = S_DOWN;
                else if (status.go_up)
                    state_next = S_UP;
                else
                    state_next = S_MUL1;
            end
            S_DOWN:
            begin
                op = OP_DOWN_SCAN;
                if (status.scan_done)
                    state_next = S_MUL1;
            end
            S_UP:
            begin
                op = OP_UP_SCAN;
                if (status.scan_done)
                    state_next = S_MUL1;
            end
            S_MUL1:
            begin
                op         = OP_MUL1;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                op         = OP_MUL2;
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (status.out_free)
                begin
                    op         = OP_RESULT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== sim/tb.sv =====
// Testbench for trigger_tap_speed_selector: tick predictor, random tap traffic, result check.
`timescale 1ns / 1ps
module tb;
    import ttss_pkg::*;

    localparam int TABLE_N = TABLE_ENTRIES_DEF;
    localparam int TAP_MAX = TAP_LIMIT_DEF;

    typedef struct packed {
        logic signed [TARGET_W-1:0] target;
        logic                       coast;
        logic [LEVEL_W-1:0]         level;
        logic                       rev;
    } tick_result_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_index = '0;
    logic [TABLE_W-1:0]         cfg_data = '0;
    logic                       in_valid = 1'b0;
    logic                       in_ready;
    logic                       trigger = 1'b0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic signed [TARGET_W-1:0] speed_target;
    logic                       motor_release;
    logic [LEVEL_W-1:0]         speed_level;
    logic                       reverse_active;

    trigger_tap_speed_selector uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .trigger        (trigger),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .speed_target   (speed_target),
        .motor_release  (motor_release),
        .speed_level    (speed_level),
        .reverse_active (reverse_active)
    );

    // predictor copy of the registers
    logic [TABLE_W-1:0] cfg_table    = SPEED_TABLE_RST;
    logic [ERPM_W-1:0]  cfg_max_erpm = MAX_ERPM_RST;
    logic [PCT_W-1:0]   cfg_rev_pct  = REVERSE_PCT_RST;
    logic [WIN_W-1:0]   cfg_window   = TAP_WINDOW_RST;
    logic [DEB_W-1:0]   cfg_debounce = DEBOUNCE_RST;
    logic [START_W-1:0] cfg_start    = START_INDEX_RST;

    // predictor copy of the tick state
    logic [LEVEL_W-1:0] lvl = '0;
    logic [PCT_W-1:0]   pct_now = '0;
    logic               cmd_open = 1'b0;
    logic               tap_held = 1'b0;
    logic [TOTAL_W-1:0] tap_count = '0;
    logic [WIN_W-1:0]   win_left = '0;
    logic               win_on = 1'b0;
    logic               win_over = 1'b0;
    logic               rev_on = 1'b0;
    logic [DEB_W-1:0]   hold_left = '0;

    tick_result_t expected_ticks[$];
    int           mismatches = 0;
    int           items_sent = 0;
    bit           idle_on = 1'b1;
    int           stall_left = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [PCT_W-1:0] pct_at(input int i);
        if (i >= TABLE_N)
            return '0;
        return cfg_table[7*i +: 7];
    endfunction

    function automatic int start_slot();
        int s;
        s = int'(cfg_start);
        if (s < 1)
            s = 1;
        if (s > TABLE_N - 1)
            s = TABLE_N - 1;
        return s;
    endfunction

    function automatic void open_window();
        win_left = (cfg_window != 0) ? cfg_window : WIN_W'(1);
        win_on   = 1'b1;
        win_over = 1'b0;
    endfunction

    function automatic void step_up();
        int i;
        i = int'(lvl) + 1;
        while (i < TABLE_N && pct_at(i) == 0)
            i++;
        if (i >= TABLE_N)
            i = TABLE_N - 1;
        lvl     = LEVEL_W'(i);
        pct_now = pct_at(i);
    endfunction

    function automatic void step_down();
        int i;
        i = (lvl > 1) ? int'(lvl) - 1 : 1;
        while (i > 0 && pct_at(i) == 0)
            i--;
        if (i < 1)
            i = 1;
        lvl     = LEVEL_W'(i);
        pct_now = pct_at(i);
    endfunction

    function automatic logic [ERPM_W-1:0] scale_pct(input logic [PCT_W-1:0] pct);
        longint v;
        v = (longint'(pct) * longint'(cfg_max_erpm)) / 100;
        if (v > longint'(cfg_max_erpm))
            v = longint'(cfg_max_erpm);
        return ERPM_W'(v);
    endfunction

    // advance the predictor by one tick and return its result
    function automatic tick_result_t advance_tick(input logic t);
        tick_result_t r;
        logic         counted;
        int           i;
        counted = 1'b0;
        if (win_on)
        begin
            if (win_left > 0)
                win_left--;
            if (win_left == 0)
            begin
                win_on   = 1'b0;
                win_over = 1'b1;
            end
        end
        if (hold_left > 0)
            hold_left--;
        else
        begin
            if (lvl == 0 && t)
            begin
                i = start_slot();
                while (pct_at(i) == 0 && i < TABLE_N - 1)
                    i++;
                lvl     = LEVEL_W'(i);
                pct_now = pct_at(i);
            end
            if (!t && !cmd_open && lvl != 0)
            begin
                cmd_open  = 1'b1;
                tap_count = '0;
                tap_held  = 1'b0;
                open_window();
                counted = 1'b1;
            end
            if (t && cmd_open && !tap_held)
            begin
                tap_count = tap_count + 1'b1;
                if (tap_count >= TAP_MAX)
                    win_over = 1'b1;
                else
                begin
                    tap_held = 1'b1;
                    open_window();
                    counted = 1'b1;
                end
            end
            if (!t && cmd_open && tap_held)
            begin
                tap_held = 1'b0;
                open_window();
                counted = 1'b1;
            end
            if (win_over)
            begin
                win_over = 1'b0;
                win_on   = 1'b0;
                win_left = '0;
                tap_held = 1'b0;
                cmd_open = 1'b0;
                if (!t && tap_count == 0)
                begin
                    lvl     = '0;
                    pct_now = '0;
                    rev_on  = 1'b0;
                end
                else if (t && tap_count == 1)
                begin
                    if (lvl == 0)
                        lvl = LEVEL_W'(start_slot());
                    else
                        step_down();
                end
                else if (tap_count == TAP_MAX)
                    rev_on = 1'b1;
                else if (t && tap_count == 2)
                begin
                    if (lvl == 0)
                        lvl = LEVEL_W'(start_slot());
                    else
                        step_up();
                end
            end
            if (counted)
                hold_left = cfg_debounce;
        end
        r.target = '0;
        r.coast  = 1'b0;
        if (rev_on)
            r.target = TARGET_W'(-longint'(scale_pct(cfg_rev_pct)));
        else if (pct_now != 0)
            r.target = TARGET_W'(scale_pct(pct_now));
        else
            r.coast = 1'b1;
        r.level = lvl;
        r.rev   = rev_on;
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatches < 40)
            $display("%0t ns: mismatch: %s", $time, what);
        mismatches++;
    endtask

    task automatic check_result();
        tick_result_t want;
        if (expected_ticks.size() == 0)
            report_mismatch("result transfer with nothing expected");
        else
        begin
            want = expected_ticks.pop_front();
            if (speed_target !== want.target)
                report_mismatch($sformatf("speed_target got %0d want %0d",
                                          speed_target, want.target));
            if (motor_release !== want.coast)
                report_mismatch($sformatf("motor_release got %b want %b",
                                          motor_release, want.coast));
            if (speed_level !== want.level)
                report_mismatch($sformatf("speed_level got %0d want %0d",
                                          speed_level, want.level));
            if (reverse_active !== want.rev)
                report_mismatch($sformatf("reverse_active got %b want %b",
                                          reverse_active, want.rev));
        end
    endtask

    // result side: check each transfer, then hold off out_ready for a random stall when idle gaps are enabled
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                check_result();
                stall_left = idle_on ? $urandom_range(0, 10) : 0;
            end
            else if (stall_left > 0)
                stall_left--;
            out_ready <= (stall_left == 0);
        end
    end

    task automatic send_tick(input logic level);
        int gap;
        gap = idle_on ? $urandom_range(0, 10) : 0;
        cfg_we <= 1'b0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        trigger  <= level;
        expected_ticks.push_back(advance_tick(level));
        items_sent++;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic hold(input logic level, input int n);
        repeat (n) send_tick(level);
    endtask

    task automatic send_pattern(input string s);
        for (int i = 0; i < s.len(); i++)
            send_tick(s[i] == "1");
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_ticks.size() > 0);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [TABLE_W-1:0] val);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_SPEED_TABLE: cfg_table    = val;
            REG_MAX_ERPM:    cfg_max_erpm = val[ERPM_W-1:0];
            REG_REVERSE_PCT: cfg_rev_pct  = val[PCT_W-1:0];
            REG_TAP_WINDOW:  cfg_window   = val[WIN_W-1:0];
            REG_DEBOUNCE:    cfg_debounce = val[DEB_W-1:0];
            REG_START_INDEX: cfg_start    = val[START_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic load_settings(input logic [TABLE_W-1:0] tbl, input int erpm, input int rev,
                                 input int win, input int deb, input int start);
        write_reg(REG_SPEED_TABLE, tbl);
        write_reg(REG_MAX_ERPM, TABLE_W'(erpm));
        write_reg(REG_REVERSE_PCT, TABLE_W'(rev));
        write_reg(REG_TAP_WINDOW, TABLE_W'(win));
        write_reg(REG_DEBOUNCE, TABLE_W'(deb));
        write_reg(REG_START_INDEX, TABLE_W'(start));
    endtask

    // one press, a random number of taps, then a hold that may let the window close
    task automatic send_command();
        int deb_c;
        int win_c;
        int taps_n;
        int settle;
        deb_c  = (cfg_debounce > 12) ? 12 : int'(cfg_debounce);
        win_c  = (cfg_window == 0) ? 1 : ((cfg_window > 6) ? 6 : int'(cfg_window));
        settle = int'(cfg_debounce) + ((cfg_window == 0) ? 1 : int'(cfg_window)) + 1;
        if (settle > 300)
            settle = 300;
        hold(1'b1, $urandom_range(1, deb_c + win_c));
        taps_n = $urandom_range(0, 5);
        repeat (taps_n)
        begin
            hold(1'b0, ($urandom_range(0, 3) != 0) ? $urandom_range(deb_c + 1, deb_c + win_c)
                                                    : $urandom_range(1, deb_c + win_c + 2));
            hold(1'b1, ($urandom_range(0, 3) != 0) ? $urandom_range(deb_c + 1, deb_c + win_c)
                                                    : $urandom_range(1, deb_c + win_c + 2));
        end
        hold(1'($urandom_range(0, 1)),
             ($urandom_range(0, 3) == 0) ? settle : $urandom_range(1, deb_c + win_c + 2));
    endtask

    task automatic run_traffic(input int n);
        int first;
        first = items_sent;
        idle_on = ($urandom_range(0, 3) != 0);
        while (items_sent - first < n)
        begin
            if ($urandom_range(0, 19) == 0)
                drain_results();
            if ($urandom_range(0, 4) == 0)
                repeat ($urandom_range(1, 8)) send_tick(1'($urandom_range(0, 1)));
            else
                send_command();
        end
    endtask

    task automatic test_directed_commands();
        idle_on = 1'b1;
        write_reg(REG_TAP_WINDOW, TABLE_W'(2));
        write_reg(REG_DEBOUNCE, TABLE_W'(0));
        send_pattern("1000");
        send_pattern("1010111");
        send_pattern("0111");
        send_pattern("01010101");
        send_pattern("0");
    endtask

    task automatic test_extreme_settings();
        load_settings(SPEED_TABLE_RST, int'(MAX_ERPM_RST), int'(REVERSE_PCT_RST),
                      int'(TAP_WINDOW_RST), int'(DEBOUNCE_RST), int'(START_INDEX_RST));
        run_traffic(80);
        load_settings('1, 100000, 100, 65535, 255, 15);
        run_traffic(60);
        load_settings('0, 0, 0, 0, 0, 0);
        run_traffic(60);
    endtask

    task automatic test_random_settings();
        logic [TABLE_W-1:0] tbl;
        int                 win;
        int                 deb;
        for (int p = 0; p < 13; p++)
        begin
            case ($urandom_range(0, 4))
                0: tbl = SPEED_TABLE_RST;
                1: tbl = '0;
                2: tbl = '1;
                3: tbl = TABLE_W'({$urandom, $urandom});
                default:
                begin
                    tbl = TABLE_W'({$urandom, $urandom});
                    for (int i = 0; i < TABLE_N; i++)
                        if ($urandom_range(0, 1) == 0)
                            tbl[7*i +: 7] = '0;
                end
            endcase
            case ($urandom_range(0, 5))
                0: win = 0;
                1: win = 125;
                default: win = $urandom_range(1, 6);
            endcase
            case ($urandom_range(0, 4))
                0: deb = 0;
                1: deb = $urandom_range(7, 20);
                default: deb = $urandom_range(0, 3);
            endcase
            load_settings(tbl, $urandom_range(0, 100000),
                          ($urandom_range(0, 7) == 0) ? 127 : $urandom_range(0, 100),
                          win, deb, $urandom_range(0, 15));
            run_traffic(60);
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_commands();
        test_extreme_settings();
        test_random_settings();
        drain_results();
        repeat (30) @(posedge clk);
        if (expected_ticks.size() > 0)
            report_mismatch($sformatf("%0d results never arrived", expected_ticks.size()));
        if (mismatches == 0)
            $display("trigger_tap_speed_selector regression: pass");
        else
            $display("trigger_tap_speed_selector regression: fail");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("timeout");
        $display("trigger_tap_speed_selector regression: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/ttss_pkg.sv
design/ttss_datapath.sv
design/ttss_controller.sv
design/trigger_tap_speed_selector.sv
sim/tb.sv
